// ----- sv/mnc_pkg.sv -----
// mnc_pkg: shared codes and types of the mahalanobis nearest cluster classifier
package mnc_pkg;

  // input item action codes
  typedef enum logic [1:0] {
    ACT_MEAN     = 2'd0,
    ACT_COV      = 2'd1,
    ACT_CLASSIFY = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_UNKNOWN   = 2'd1,
    CFG_COUNT     = 2'd2,
    CFG_SPARE     = 2'd3
  } cfg_index_t;

  // classify sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_COV,
    ST_DRAIN,
    ST_EVAL,
    ST_DONE
  } state_t;

  localparam int DIFF_W = 18;
  localparam int PROD_W = 36;
  localparam int ACC_W  = 72;
  localparam int COEF_W = 32;
  localparam int DIST_W = 64;
  localparam logic signed [DIST_W-1:0] SAT_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] SAT_MIN = {1'b1, {(DIST_W-1){1'b0}}};
  localparam logic [62:0] THRESHOLD_RESET = 63'd2199023;
  localparam logic [7:0] UNKNOWN_RESET = 8'd255;

endpackage

// ----- sv/mnc_ram.sv -----
// mnc_ram: generic single write port ram with registered read
module mnc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 24
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/mahalanobis_nearest_cluster.sv -----
// mahalanobis_nearest_cluster: nearest cluster by squared mahalanobis distance
// load items write the mean or inverse covariance ram at once
// classify steps through the n clusters in use one after another
// (per cluster: DIM mean reads, DIM*DIM inverse covariance reads, a pipeline drain, a compare)
// one item at a time; the result waits in an output register while input resumes
// synchronous active-high reset clears control and config; rams hold no reset
module mahalanobis_nearest_cluster #(
  parameter int MAX_CLUSTERS = 8,
  parameter int DIM = 3
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [2:0]         cluster,
  input  logic [1:0]         row,
  input  logic [1:0]         col,
  input  logic signed [31:0] coef_value,
  input  logic [7:0]         comp0,
  input  logic [7:0]         comp1,
  input  logic [7:0]         comp2,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         label,
  output logic               is_unknown,
  output logic signed [63:0] min_distance,
  // configuration channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam int MEAN_DEPTH = MAX_CLUSTERS * DIM;
  localparam int COV_DEPTH  = MAX_CLUSTERS * DIM * DIM;
  localparam int MAW  = MEAN_DEPTH > 1 ? $clog2(MEAN_DEPTH) : 1;
  localparam int CAW  = COV_DEPTH > 1 ? $clog2(COV_DEPTH) : 1;
  localparam int KW   = DIM > 1 ? $clog2(DIM) : 1;
  localparam int CW   = MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1;
  localparam int NW   = $clog2(MAX_CLUSTERS + 1);

  mnc_pkg::state_t state, state_next;

  // configuration registers
  logic [62:0] distance_threshold;
  logic [7:0]  unknown_label;
  logic [3:0]  cluster_count;

  // sample and per-cluster working registers
  logic [7:0]                        xs [DIM];
  logic [7:0]                        comp_all [3];
  logic signed [mnc_pkg::DIFF_W-1:0] d [DIM];
  logic [NW-1:0]                     n_clusters, n_start;
  logic [NW-1:0]                     c_idx;
  logic [KW-1:0]                     k, ci, cj;
  logic [MAW-1:0]                    mean_base;
  logic [CAW-1:0]                    cov_base, cov_off;
  logic signed [mnc_pkg::ACC_W-1:0]  acc;
  logic signed [mnc_pkg::DIST_W-1:0] best, clus_dist;
  logic [CW-1:0]                     best_c;

  // pipeline registers
  logic                              m_vld;
  logic [KW-1:0]                     m_idx;
  logic                              s1_vld, s2_vld, s3_vld;
  logic [KW-1:0]                     s1_i, s1_j;
  logic signed [mnc_pkg::PROD_W-1:0] s2_p;
  logic signed [31:0]                s2_a;
  logic signed [49:0]                s3_lo;
  logic signed [50:0]                s3_hi;
  logic signed [mnc_pkg::ACC_W-1:0]  hi_ext, lo_ext;

  // ram ports
  logic               mean_we, cov_we;
  logic [MAW-1:0]     mean_waddr, mean_raddr;
  logic [CAW-1:0]     cov_waddr, cov_raddr;
  logic [15:0]        mean_wdata, mean_rdata;
  logic [31:0]        cov_rdata;

  // control decoded from state
  logic in_accept, start, mean_issue, cov_issue, eval, out_load, out_free, last_cov;

  assign comp_all = '{comp0, comp1, comp2};
  assign in_accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;
  assign last_cov = (ci == KW'(DIM - 1)) && (cj == KW'(DIM - 1));
  assign n_start = (32'(cluster_count) > MAX_CLUSTERS) ? NW'(MAX_CLUSTERS)
                                                        : NW'(cluster_count);

  // load decode and ram write side
  always_comb begin
    mean_we = in_accept && (action == mnc_pkg::ACT_MEAN) &&
              (32'(cluster) < MAX_CLUSTERS) && (32'(row) < DIM);
    cov_we  = in_accept && (action == mnc_pkg::ACT_COV) &&
              (32'(cluster) < MAX_CLUSTERS) && (32'(row) < DIM) && (32'(col) < DIM);
    mean_waddr = MAW'(32'(cluster) * DIM + 32'(row));
    cov_waddr  = CAW'((32'(cluster) * DIM + 32'(row)) * DIM + 32'(col));
    if (coef_value < 0) begin
      mean_wdata = 16'd0;
    end else if (coef_value > 32'sd65535) begin
      mean_wdata = 16'hFFFF;
    end else begin
      mean_wdata = coef_value[15:0];
    end
  end

  mnc_ram #(.WIDTH(16), .DEPTH(MEAN_DEPTH)) u_mean_ram (
    .clk   (clk),
    .we    (mean_we),
    .waddr (mean_waddr),
    .wdata (mean_wdata),
    .raddr (mean_raddr),
    .rdata (mean_rdata)
  );

  mnc_ram #(.WIDTH(32), .DEPTH(COV_DEPTH)) u_cov_ram (
    .clk   (clk),
    .we    (cov_we),
    .waddr (cov_waddr),
    .wdata (coef_value),
    .raddr (cov_raddr),
    .rdata (cov_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mnc_pkg::ST_IDLE: begin
        if (in_accept && (action == mnc_pkg::ACT_CLASSIFY)) begin
          state_next = (n_start == '0) ? mnc_pkg::ST_DONE : mnc_pkg::ST_MEAN;
        end
      end
      mnc_pkg::ST_MEAN: begin
        if (k == KW'(DIM - 1)) state_next = mnc_pkg::ST_COV;
      end
      mnc_pkg::ST_COV: begin
        if (last_cov) state_next = mnc_pkg::ST_DRAIN;
      end
      mnc_pkg::ST_DRAIN: begin
        if (!s1_vld && !s2_vld && !s3_vld) state_next = mnc_pkg::ST_EVAL;
      end
      mnc_pkg::ST_EVAL: begin
        state_next = (c_idx == n_clusters - NW'(1)) ? mnc_pkg::ST_DONE : mnc_pkg::ST_MEAN;
      end
      mnc_pkg::ST_DONE: begin
        if (out_free) state_next = mnc_pkg::ST_IDLE;
      end
      default: state_next = mnc_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall   = (state != mnc_pkg::ST_IDLE);
    start      = (state == mnc_pkg::ST_IDLE) && in_accept && (action == mnc_pkg::ACT_CLASSIFY);
    mean_issue = (state == mnc_pkg::ST_MEAN);
    cov_issue  = (state == mnc_pkg::ST_COV);
    eval       = (state == mnc_pkg::ST_EVAL);
    out_load   = (state == mnc_pkg::ST_DONE) && out_free;
    mean_raddr = mean_base + MAW'(k);
    cov_raddr  = cov_base + cov_off;
  end

  // saturate accumulated quadratic form
  always_comb begin
    if ((&acc[71:63]) || !(|acc[71:63])) begin
      clus_dist = acc[63:0];
    end else begin
      clus_dist = acc[71] ? mnc_pkg::SAT_MIN : mnc_pkg::SAT_MAX;
    end
    hi_ext = mnc_pkg::ACC_W'(s3_hi);
    lo_ext = mnc_pkg::ACC_W'(s3_lo);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mnc_pkg::ST_IDLE;
      out_valid <= 1'b0;
      m_vld <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      distance_threshold <= mnc_pkg::THRESHOLD_RESET;
      unknown_label <= mnc_pkg::UNKNOWN_RESET;
      cluster_count <= 4'd0;
    end else begin
      state <= state_next;
      m_vld <= mean_issue;
      s1_vld <= cov_issue;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mnc_pkg::CFG_THRESHOLD: distance_threshold <= cfg_data[62:0];
          mnc_pkg::CFG_UNKNOWN:   unknown_label <= cfg_data[7:0];
          mnc_pkg::CFG_COUNT:     cluster_count <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // sequencer counters and ram bases
  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < DIM; i++) xs[i] <= comp_all[i];
      n_clusters <= n_start;
      c_idx <= '0;
      mean_base <= '0;
      cov_base <= '0;
      k <= '0;
      ci <= '0;
      cj <= '0;
      cov_off <= '0;
      best <= mnc_pkg::SAT_MAX;
      best_c <= '0;
    end
    if (mean_issue) k <= k + KW'(1);
    if (cov_issue) begin
      cov_off <= cov_off + CAW'(1);
      if (cj == KW'(DIM - 1)) begin
        cj <= '0;
        ci <= ci + KW'(1);
      end else begin
        cj <= cj + KW'(1);
      end
    end
    if (eval) begin
      if (c_idx == '0 || clus_dist < best) begin
        best <= clus_dist;
        best_c <= CW'(c_idx);
      end
      c_idx <= c_idx + NW'(1);
      mean_base <= mean_base + MAW'(DIM);
      cov_base <= cov_base + CAW'(DIM * DIM);
      k <= '0;
      ci <= '0;
      cj <= '0;
      cov_off <= '0;
    end
  end

  // difference capture and multiply-accumulate chain
  always_ff @(posedge clk) begin
    m_idx <= k;
    s1_i <= ci;
    s1_j <= cj;
    if (m_vld) begin
      d[m_idx] <= $signed({2'b00, xs[m_idx], 8'd0}) - $signed({2'b00, mean_rdata});
    end
    s2_p <= d[s1_i] * d[s1_j];
    s2_a <= cov_rdata;
    s3_lo <= $signed({1'b0, s2_p[16:0]}) * s2_a;
    s3_hi <= $signed(s2_p[35:17]) * s2_a;
    if (start || eval) begin
      acc <= '0;
    end else if (s3_vld) begin
      acc <= acc + (hi_ext <<< 17) + lo_ext;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      min_distance <= best;
      if ((n_clusters != '0) && (best < $signed({1'b0, distance_threshold}))) begin
        label <= 8'(best_c);
        is_unknown <= 1'b0;
      end else begin
        label <= unknown_label;
        is_unknown <= 1'b1;
      end
    end
  end

endmodule

// ----- sv/mnc_checker.sv -----
// mnc_checker: port-level checks of the nearest cluster classifier
module mnc_checker #(
  parameter int MAX_CLUSTERS = 8
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  action,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  label,
  input logic        is_unknown,
  input logic [63:0] min_distance
);

  // a classify transfer blocks the input next cycle
  a_busy_after_classify: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (action == mnc_pkg::ACT_CLASSIFY) |=> in_stall)
    else $error("input not stalled after classify transfer");

  // a known label is a cluster index
  a_label_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_unknown |-> (32'(label) < MAX_CLUSTERS))
    else $error("known label out of cluster range");

  // a known label never carries the saturated maximum distance
  a_known_not_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_unknown |-> (min_distance != 64'h7FFF_FFFF_FFFF_FFFF))
    else $error("known label with saturated distance");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(min_distance) && $stable(label))
    else $error("stalled result changed");

endmodule

bind mahalanobis_nearest_cluster mnc_checker #(.MAX_CLUSTERS(MAX_CLUSTERS)) u_mnc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .action       (action),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .label        (label),
  .is_unknown   (is_unknown),
  .min_distance (min_distance)
);
